// ----- src/dtc_pkg.sv -----
// Package for the domino tiling counter: sizes, register indexes and FSM state type.
`default_nettype none
package dtc_pkg;

   localparam int MAX_ROWS   = 12;
   localparam int MAX_COLS   = 64;
   localparam int GRID_DEPTH = MAX_ROWS * MAX_COLS;
   localparam int BANK_DEPTH = 1 << MAX_ROWS;

   localparam int ROW_W      = $clog2(MAX_ROWS + 1);
   localparam int COL_W      = $clog2(MAX_COLS + 1);
   localparam int ROWIDX_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int COLIDX_W   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int FILL_W     = $clog2(GRID_DEPTH + 1);
   localparam int GRID_AW    = (GRID_DEPTH > 1) ? $clog2(GRID_DEPTH) : 1;
   localparam int BANK_AW    = MAX_ROWS;
   localparam int COUNT_W    = 64;
   localparam int CSR_W      = (ROW_W > COL_W) ? ROW_W : COL_W;

   localparam logic CSR_ROWS = 1'b0;
   localparam logic CSR_COLS = 1'b1;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_FLAGS,
      ST_SWEEP,
      ST_DRAIN,
      ST_FIN_READ,
      ST_FIN_CAP
   } dtc_state_type;

endpackage
`default_nettype wire

// ----- src/domino_tiling_counter.sv -----
// Domino tiling counter: grid load, broken-profile sweep over two count banks, result output.
//
// Usage:
//  - csr_write_en/csr_index/csr_wdata set rows (index 0) and cols (index 1) while idle.
//  - Requests carry one grid cell each (req_free, req_last), column-major, rows cells a
//    column. Cells are taken one per cycle while loading; cells past the grid store drop.
//  - The request with req_last set starts the sweep; no request is taken until it ends.
//    For each of rows*cols cells the block fetches the three grid flags (cell, below, right)
//    through the registered grid read, then streams the 2^rows profile entries through the
//    count banks (one entry a cycle, two reads and one write per cycle). rsp_valid rises
//    after the last cell is swept and the drain, final read and capture states pass; the
//    profile stream is set by the single write port of each bank.
//  - The result appears on rsp_tiling_count with rsp_valid and stays until rsp_ready.
//    Loading of the next grid goes on while a result waits; a second sweep holds its
//    result in the bank until the output register frees.
//  - Reset (synchronous, active high) sets rows and cols to 1, empties the grid (unsent
//    cells count as blocked, tracked by a fill count) and drops any pending result.
//    The count banks need no clearing: the first cell step reads a virtual start profile.
`default_nettype none
module domino_tiling_counter (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_write_en,
   input  wire logic                          csr_index,
   input  wire logic [dtc_pkg::CSR_W-1:0]     csr_wdata,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic                          req_free,
   input  wire logic                          req_last,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [dtc_pkg::COUNT_W-1:0]        rsp_tiling_count
);
   import dtc_pkg::*;

   // configuration
   logic [ROW_W-1:0]    rows_ff;
   logic [COL_W-1:0]    cols_ff;
   logic [ROW_W-1:0]    r_eff;
   logic [COL_W-1:0]    c_eff;

   // control
   dtc_state_type       state_ff, state_in;
   logic [FILL_W-1:0]   fill_ff, fill_in;
   logic [FILL_W-1:0]   cell_ff, cell_in;
   logic [ROWIDX_W-1:0] row_ff, row_in;
   logic [COLIDX_W-1:0] col_ff, col_in;
   logic [1:0]          phase_ff, phase_in;
   logic [BANK_AW-1:0]  x_ff, x_in;
   logic                cur_sel_ff, cur_sel_in;
   logic                first_ff, first_in;
   logic                fc_ff, fc_in;
   logic                fb_ff, fb_in;
   logic                fr_ff, fr_in;

   // grid store
   logic                grid_mem [GRID_DEPTH];
   logic                grid_q_ff;
   logic                grid_ok_ff;
   logic [FILL_W:0]     grid_sum;
   logic                grid_ok;
   logic [GRID_AW-1:0]  grid_raddr;
   logic                grid_we;
   logic                grid_flag;

   // count banks
   logic [COUNT_W-1:0]  bank_a_mem [BANK_DEPTH];
   logic [COUNT_W-1:0]  bank_b_mem [BANK_DEPTH];
   logic [COUNT_W-1:0]  a_rd0_ff, a_rd1_ff, b_rd0_ff, b_rd1_ff;
   logic [BANK_AW-1:0]  rd0_addr, rd1_addr;

   // sweep stage 0 terms
   logic [BANK_AW:0]    prof_full;
   logic [BANK_AW-1:0]  prof_last;
   logic [BANK_AW-1:0]  top;
   logic [BANK_AW-1:0]  x_twice;
   logic [BANK_AW-1:0]  x_high_twice;
   logic                lower;
   logic                fb_eff, fr_eff;
   logic                use0, use1;
   logic                row_end, col_end;

   // sweep stage 1 (write back)
   logic                s1_valid_ff, s1_valid_in;
   logic [BANK_AW-1:0]  s1_x_ff;
   logic                s1_use0_ff, s1_use1_ff;
   logic                s1_one0_ff, s1_one1_ff;
   logic                s1_first_ff;
   logic                s1_rsel_ff;
   logic [COUNT_W-1:0]  s1_d0, s1_d1, s1_sum;

   // result register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0]  rsp_count_ff;
   logic                rsp_load;
   logic [COUNT_W-1:0]  final_count;

   logic                req_take;

   // clamp configuration into range
   always_comb begin
      if (rows_ff == '0) begin
         r_eff = ROW_W'(1);
      end else if (rows_ff > ROW_W'(MAX_ROWS)) begin
         r_eff = ROW_W'(MAX_ROWS);
      end else begin
         r_eff = rows_ff;
      end
      if (cols_ff == '0) begin
         c_eff = COL_W'(1);
      end else if (cols_ff > COL_W'(MAX_COLS)) begin
         c_eff = COL_W'(MAX_COLS);
      end else begin
         c_eff = cols_ff;
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= ROW_W'(1);
         cols_ff <= COL_W'(1);
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_ROWS: rows_ff <= csr_wdata[ROW_W-1:0];
            CSR_COLS: cols_ff <= csr_wdata[COL_W-1:0];
            default:  ;
         endcase
      end
   end

   assign req_ready = (state_ff == ST_LOAD);
   assign req_take  = req_valid && req_ready;
   assign grid_we   = req_take && (fill_ff < FILL_W'(GRID_DEPTH));

   // grid flag address for the current fetch phase
   always_comb begin
      unique case (phase_ff)
         2'd0:    grid_sum = {1'b0, cell_ff};
         2'd1:    grid_sum = {1'b0, cell_ff} + (FILL_W+1)'(1);
         2'd2:    grid_sum = {1'b0, cell_ff} + (FILL_W+1)'(r_eff);
         default: grid_sum = {1'b0, cell_ff};
      endcase
      grid_ok    = grid_sum < {1'b0, fill_ff};
      grid_raddr = grid_ok ? grid_sum[GRID_AW-1:0] : '0;
   end

   // grid store: written while loading, read during flag fetch
   always_ff @(posedge clock) begin
      if (grid_we) begin
         grid_mem[fill_ff[GRID_AW-1:0]] <= req_free;
      end
      grid_q_ff  <= grid_mem[grid_raddr];
      grid_ok_ff <= grid_ok;
   end
   assign grid_flag = grid_q_ff && grid_ok_ff;

   // profile geometry and pull addresses for next-bank entry x
   always_comb begin
      prof_full    = (BANK_AW+1)'(1) << r_eff;
      prof_last    = BANK_AW'(prof_full - (BANK_AW+1)'(1));
      top          = BANK_AW'(prof_full >> 1);
      lower        = x_ff < top;
      x_twice      = BANK_AW'({x_ff, 1'b0});
      x_high_twice = BANK_AW'({x_ff - top, 1'b0});
      row_end      = (row_ff == ROWIDX_W'(r_eff - ROW_W'(1)));
      col_end      = (col_ff == COLIDX_W'(c_eff - COL_W'(1)));
      fb_eff       = fb_ff && !row_end;
      fr_eff       = fr_ff && !col_end;
      rd0_addr     = '0;
      rd1_addr     = '0;
      use0         = 1'b0;
      use1         = 1'b0;
      if (state_ff == ST_SWEEP) begin
         if (!fc_ff) begin
            // blocked cell: both masks with this base carry over
            if (lower) begin
               rd0_addr = x_twice;
               rd1_addr = x_twice | BANK_AW'(1);
               use0     = 1'b1;
               use1     = 1'b1;
            end
         end else if (lower) begin
            // skip an occupied bit, or take a vertical domino from below
            rd0_addr = x_twice | BANK_AW'(1);
            rd1_addr = x_twice - BANK_AW'(2);
            use0     = 1'b1;
            use1     = fb_eff && x_ff[0];
         end else begin
            // horizontal domino into the next column
            rd0_addr = x_high_twice;
            use0     = fr_eff;
         end
      end
   end

   // count banks: two reads, one write each
   always_ff @(posedge clock) begin
      if (s1_valid_ff && s1_rsel_ff) begin
         bank_a_mem[s1_x_ff] <= s1_sum;
      end
      if (s1_valid_ff && !s1_rsel_ff) begin
         bank_b_mem[s1_x_ff] <= s1_sum;
      end
      a_rd0_ff <= bank_a_mem[rd0_addr];
      a_rd1_ff <= bank_a_mem[rd1_addr];
      b_rd0_ff <= bank_b_mem[rd0_addr];
      b_rd1_ff <= bank_b_mem[rd1_addr];
   end

   // stage 1: add the pulled counts; the first cell reads the start profile
   always_comb begin
      if (s1_first_ff) begin
         s1_d0 = COUNT_W'(s1_one0_ff);
         s1_d1 = COUNT_W'(s1_one1_ff);
      end else if (s1_rsel_ff) begin
         s1_d0 = b_rd0_ff;
         s1_d1 = b_rd1_ff;
      end else begin
         s1_d0 = a_rd0_ff;
         s1_d1 = a_rd1_ff;
      end
      s1_sum = (s1_use0_ff ? s1_d0 : '0) + (s1_use1_ff ? s1_d1 : '0);
   end

   assign s1_valid_in = (state_ff == ST_SWEEP);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      s1_x_ff     <= x_ff;
      s1_use0_ff  <= use0;
      s1_use1_ff  <= use1;
      s1_one0_ff  <= (rd0_addr == '0);
      s1_one1_ff  <= (rd1_addr == '0);
      s1_first_ff <= first_ff;
      s1_rsel_ff  <= cur_sel_ff;
   end

   assign final_count = cur_sel_ff ? b_rd0_ff : a_rd0_ff;
   assign rsp_load    = (state_ff == ST_FIN_CAP) && (!rsp_valid_ff || rsp_ready);

   // next state and sequencing
   always_comb begin
      state_in   = state_ff;
      fill_in    = fill_ff;
      cell_in    = cell_ff;
      row_in     = row_ff;
      col_in     = col_ff;
      phase_in   = phase_ff;
      x_in       = x_ff;
      cur_sel_in = cur_sel_ff;
      first_in   = first_ff;
      fc_in      = fc_ff;
      fb_in      = fb_ff;
      fr_in      = fr_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (grid_we) begin
               fill_in = fill_ff + FILL_W'(1);
            end
            if (req_take && req_last) begin
               state_in   = ST_FLAGS;
               cell_in    = '0;
               row_in     = '0;
               col_in     = '0;
               phase_in   = '0;
               cur_sel_in = 1'b0;
               first_in   = 1'b1;
            end
         end
         ST_FLAGS: begin
            phase_in = phase_ff + 2'd1;
            unique case (phase_ff)
               2'd0: ;
               2'd1: fc_in = grid_flag;
               2'd2: fb_in = grid_flag;
               2'd3: begin
                  fr_in    = grid_flag;
                  x_in     = '0;
                  state_in = ST_SWEEP;
               end
               default: ;
            endcase
         end
         ST_SWEEP: begin
            x_in = x_ff + BANK_AW'(1);
            if (x_ff == prof_last) begin
               // cell done: swap banks and advance to the next cell
               cur_sel_in = !cur_sel_ff;
               first_in   = 1'b0;
               cell_in    = cell_ff + FILL_W'(1);
               phase_in   = '0;
               state_in   = ST_FLAGS;
               if (row_end) begin
                  row_in = '0;
                  if (col_end) begin
                     state_in = ST_DRAIN;
                  end else begin
                     col_in = col_ff + COLIDX_W'(1);
                  end
               end else begin
                  row_in = row_ff + ROWIDX_W'(1);
               end
            end
         end
         ST_DRAIN: begin
            state_in = ST_FIN_READ;
         end
         ST_FIN_READ: begin
            state_in = ST_FIN_CAP;
         end
         ST_FIN_CAP: begin
            if (rsp_load) begin
               // result taken into the output register: drop the grid
               fill_in  = '0;
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_LOAD;
         fill_ff    <= '0;
         cell_ff    <= '0;
         row_ff     <= '0;
         col_ff     <= '0;
         phase_ff   <= '0;
         x_ff       <= '0;
         cur_sel_ff <= 1'b0;
         first_ff   <= 1'b1;
      end else begin
         state_ff   <= state_in;
         fill_ff    <= fill_in;
         cell_ff    <= cell_in;
         row_ff     <= row_in;
         col_ff     <= col_in;
         phase_ff   <= phase_in;
         x_ff       <= x_in;
         cur_sel_ff <= cur_sel_in;
         first_ff   <= first_in;
      end
      fc_ff <= fc_in;
      fb_ff <= fb_in;
      fr_ff <= fr_in;
   end

   // output register: hold until the receiver takes the result
   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (rsp_load) begin
         rsp_count_ff <= final_count;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_tiling_count = rsp_count_ff;

endmodule
`default_nettype wire
